/* rtl/tksd_pkg.sv */
package tksd_pkg;

   // Key kinds carried in the result's key_kind field.
   localparam logic [3:0] KEY_PLAIN = 4'd0;
   localparam logic [3:0] KEY_ENTER = 4'd1;
   localparam logic [3:0] KEY_UP    = 4'd2;
   localparam logic [3:0] KEY_DOWN  = 4'd3;
   localparam logic [3:0] KEY_PGUP  = 4'd4;
   localparam logic [3:0] KEY_PGDN  = 4'd5;
   localparam logic [3:0] KEY_HOME  = 4'd6;
   localparam logic [3:0] KEY_END   = 4'd7;
   localparam logic [3:0] KEY_ESC   = 4'd8;
   localparam logic [3:0] KEY_UNREC = 4'd9;

   // Input event kinds.
   localparam logic MODE_BYTE  = 1'b0;
   localparam logic MODE_QUIET = 1'b1;

   // Configuration register indexes.
   localparam int          CSR_INDEX_W     = 2;
   localparam logic [1:0]  CSR_ARROW_LEFT  = 2'd0;
   localparam logic [1:0]  CSR_ARROW_RIGHT = 2'd1;
   localparam logic [1:0]  CSR_ARROW_UP    = 2'd2;
   localparam logic [1:0]  CSR_ARROW_DOWN  = 2'd3;

   // Result queue geometry.
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] key_kind;
      logic [7:0] raw_byte;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] left_code;
      logic [7:0] right_code;
      logic [7:0] up_code;
      logic [7:0] down_code;
   } arrow_codes_type;

   // Results produced by one accepted event, first result in res0.
   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type res0;
      rsp_payload_type res1;
   } push_type;

endpackage

/* rtl/tksd_csr.sv */
module tksd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [tksd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                          csr_wdata,
   output tksd_pkg::arrow_codes_type           arrow_codes
);

   tksd_pkg::arrow_codes_type codes_ff;
   tksd_pkg::arrow_codes_type codes_in;

   always_comb begin
      codes_in = codes_ff;
      if (csr_write_en) begin
         case (csr_index)
            tksd_pkg::CSR_ARROW_LEFT:  codes_in.left_code  = csr_wdata;
            tksd_pkg::CSR_ARROW_RIGHT: codes_in.right_code = csr_wdata;
            tksd_pkg::CSR_ARROW_UP:    codes_in.up_code    = csr_wdata;
            tksd_pkg::CSR_ARROW_DOWN:  codes_in.down_code  = csr_wdata;
            default:                   codes_in = codes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.left_code  <= 8'd2;
         codes_ff.right_code <= 8'd3;
         codes_ff.up_code    <= 8'd4;
         codes_ff.down_code  <= 8'd5;
      end else begin
         codes_ff <= codes_in;
      end
   end

   assign arrow_codes = codes_ff;

endmodule

/* rtl/tksd_parse.sv */
module tksd_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  tksd_pkg::req_payload_type    req,
   input  tksd_pkg::arrow_codes_type    arrow_codes,
   output tksd_pkg::push_type           push
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_ESC  = 2'd1;
   localparam logic [1:0] PH_SEQ  = 2'd2;
   localparam logic [1:0] PH_TAIL = 2'd3;

   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CSI = 8'h5B;
   localparam logic [7:0] CH_SS3 = 8'h4F;

   logic [1:0] phase_ff, phase_in;
   logic [2:0] held_ff, held_in;
   logic       quiet;
   logic [7:0] c;
   tksd_pkg::push_type p;

   assign quiet = (req.mode == tksd_pkg::MODE_QUIET);
   assign c     = req.data_byte;

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      p        = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (!quiet) begin
               p.count = 2'd1;
               if (c == CH_CR || c == CH_LF) begin
                  p.res0.key_kind = tksd_pkg::KEY_ENTER;
               end else if (c == arrow_codes.left_code) begin
                  p.res0.key_kind = tksd_pkg::KEY_PGUP;
               end else if (c == arrow_codes.right_code) begin
                  p.res0.key_kind = tksd_pkg::KEY_PGDN;
               end else if (c == arrow_codes.up_code) begin
                  p.res0.key_kind = tksd_pkg::KEY_UP;
               end else if (c == arrow_codes.down_code) begin
                  p.res0.key_kind = tksd_pkg::KEY_DOWN;
               end else if (c == CH_ESC) begin
                  p.count  = 2'd0;
                  phase_in = PH_ESC;
               end else begin
                  p.res0.key_kind = tksd_pkg::KEY_PLAIN;
                  p.res0.raw_byte = c;
               end
            end
         end
         PH_ESC: begin
            if (quiet) begin
               p.count         = 2'd1;
               p.res0.key_kind = tksd_pkg::KEY_ESC;
               phase_in        = PH_IDLE;
            end else if (c == CH_CSI || c == CH_SS3) begin
               phase_in = PH_SEQ;
            end else begin
               // A lone escape followed by an ordinary byte passed through raw.
               p.count         = 2'd2;
               p.res0.key_kind = tksd_pkg::KEY_ESC;
               p.res1.key_kind = tksd_pkg::KEY_PLAIN;
               p.res1.raw_byte = c;
               phase_in        = PH_IDLE;
            end
         end
         PH_SEQ: begin
            if (!quiet) begin
               phase_in = PH_IDLE;
               p.count  = 2'd1;
               case (c)
                  8'h41: p.res0.key_kind = tksd_pkg::KEY_UP;
                  8'h42: p.res0.key_kind = tksd_pkg::KEY_DOWN;
                  8'h43: p.res0.key_kind = tksd_pkg::KEY_PGDN;
                  8'h44: p.res0.key_kind = tksd_pkg::KEY_PGUP;
                  8'h48: p.res0.key_kind = tksd_pkg::KEY_HOME;
                  8'h46: p.res0.key_kind = tksd_pkg::KEY_END;
                  8'h35: begin
                     p.count  = 2'd0;
                     held_in  = tksd_pkg::KEY_PGUP[2:0];
                     phase_in = PH_TAIL;
                  end
                  8'h36: begin
                     p.count  = 2'd0;
                     held_in  = tksd_pkg::KEY_PGDN[2:0];
                     phase_in = PH_TAIL;
                  end
                  8'h31: begin
                     p.count  = 2'd0;
                     held_in  = tksd_pkg::KEY_HOME[2:0];
                     phase_in = PH_TAIL;
                  end
                  8'h34: begin
                     p.count  = 2'd0;
                     held_in  = tksd_pkg::KEY_END[2:0];
                     phase_in = PH_TAIL;
                  end
                  default: p.res0.key_kind = tksd_pkg::KEY_UNREC;
               endcase
            end
         end
         default: begin
            // Any byte closes the numbered sequence and is swallowed.
            if (!quiet) begin
               p.count         = 2'd1;
               p.res0.key_kind = {1'b0, held_ff};
               held_in         = 3'd0;
               phase_in        = PH_IDLE;
            end
         end
      endcase
      p.res0.last = (p.count == 2'd1);
      p.res1.last = (p.count == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= 3'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   always_comb begin
      push       = p;
      push.count = fire ? p.count : 2'd0;
   end

endmodule

/* rtl/tksd_rspq.sv */
module tksd_rspq (
   input  logic                       clock,
   input  logic                       reset,
   input  tksd_pkg::push_type         push,
   input  logic                       pop,
   output logic                       rsp_valid,
   output tksd_pkg::rsp_payload_type  rsp_payload,
   output logic                       full
);

   localparam int PW = tksd_pkg::RSPQ_PTR_W;
   localparam int CW = tksd_pkg::RSPQ_CNT_W;

   tksd_pkg::rsp_payload_type entry_ff [tksd_pkg::RSPQ_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] wr_next;

   assign wr_next   = wr_ptr_ff + PW'(1);
   assign wr_ptr_in = wr_ptr_ff + PW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + CW'(push.count) - CW'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   // Keep room for the two results one event can produce.
   assign full        = (count_ff > CW'(tksd_pkg::RSPQ_DEPTH - 2));

endmodule

/* rtl/terminal_key_sequence_decoder_top.sv */
// Channel   | Direction | Handshake             | Payload
// req_      | in        | req_valid / req_stall | mode, data_byte
// rsp_      | out       | rsp_valid / rsp_stall | key_kind, raw_byte, last
// csr_      | in        | csr_write_en          | csr_index, csr_wdata (no read-back)
//
// An event is decoded in the cycle it is transferred in; its results show on
// the rsp_ side from the next cycle on, one result transfer per cycle while rsp_stall is low.
// One event per cycle is taken while results drain; a four-entry result queue
// sets the figure, and req_stall rises only when fewer than two slots are free.
// Reset is synchronous and active high; it restores the arrow codes and idles
// the parser and the queue. rsp_stall only backs the queue up.
//
// The decoder reads terminal bytes and quiet-line events and turns them into
// key codes. CR and LF give enter, the four programmable arrow bytes give page
// up, page down, up and down, and ESC opens an escape sequence. A single event
// can produce two results (escape followed by the raw byte), and the last flag
// marks the final result of each event.
module terminal_key_sequence_decoder_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tksd_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tksd_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_write_en,
   input  logic [tksd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                          csr_wdata
);

   tksd_pkg::arrow_codes_type arrow_codes;
   tksd_pkg::push_type        push;
   logic                      queue_full;
   logic                      req_fire;
   logic                      rsp_fire;

   // The input side stalls only on queue space, never on rsp_stall directly.
   assign req_stall = queue_full;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid && !rsp_stall;

   // Arrow code registers.
   tksd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .arrow_codes  (arrow_codes)
   );

   // Escape sequence parser: phase and held key registers plus the decode.
   tksd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .req         (req_payload),
      .arrow_codes (arrow_codes),
      .push        (push)
   );

   // Result queue that separates the two sides.
   tksd_rspq u_rspq (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .pop         (rsp_fire),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .full        (queue_full)
   );

endmodule

/* rtl/tksd_checker.sv */
module tksd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input tksd_pkg::rsp_payload_type  rsp_payload
);

   // A held result stays put until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // Only plain keys carry a byte.
   a_raw_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.key_kind == tksd_pkg::KEY_PLAIN ||
                     rsp_payload.raw_byte == 8'd0))
      else $error("raw byte on a non-plain key");

   // An escape followed by another result of the same event is a plain byte.
   a_esc_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_payload.key_kind == tksd_pkg::KEY_ESC &&
      !rsp_payload.last |=> rsp_valid && rsp_payload.key_kind == tksd_pkg::KEY_PLAIN &&
      rsp_payload.last)
      else $error("escape pair broken");

endmodule

bind terminal_key_sequence_decoder_top tksd_checker u_tksd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
